@@ rtl/fmodf_pkg.sv @@
// Shared constants and stage payload types for the binary64 modf splitter.
package fmodf_pkg;
  localparam int unsigned MantW = 52;
  localparam int unsigned ExpW = 11;
  localparam logic [ExpW-1:0] ExpAll = 11'h7FF;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  // Stage 1 to stage 2: decoded input with the fraction bits isolated.
  typedef struct packed {
    logic [63:0]      x;
    logic             special; // result fully known, no normalisation needed
    logic [63:0]      frac_fix;
    logic [63:0]      int_bits;
    logic [MantW-1:0] fb;
  } s1_t;

  // Stage 2 to stage 3: fraction with its leading-one position.
  typedef struct packed {
    logic [63:0]      x;
    logic             special;
    logic [63:0]      frac_fix;
    logic [63:0]      int_bits;
    logic [MantW-1:0] fb;
    logic [5:0]       p;
  } s2_t;
endpackage

@@ rtl/fmodf_if.sv @@
// Valid/ready channel interface carrying one 64-bit request payload group.
interface fmodf_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fmodf_out_if.sv @@
// Valid/ready channel interface for the result pair.
interface fmodf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frac_bits;
  logic [63:0] int_bits;
  modport source (output valid, output frac_bits, output int_bits, input ready);
  modport sink (input valid, input frac_bits, input int_bits, output ready);
endinterface

@@ rtl/fmodf_decode.sv @@
// Stage 1 logic: classifies the operand and masks off the fraction bits.
module fmodf_decode (
  input  logic [63:0]     x,
  output fmodf_pkg::s1_t  s1
);
  import fmodf_pkg::*;
  logic [ExpW-1:0]  ex;
  logic [MantW-1:0] mant;
  logic [ExpW-1:0]  e;
  logic [MantW-1:0] fmask;
  logic [63:0]      sgn;

  always_comb begin
    ex = x[62:52];
    mant = x[MantW-1:0];
    sgn = x & SignBit;
    e = ex - ExpBias;
    fmask = '0;
    s1.x = x;
    s1.special = 1'b1;
    s1.frac_fix = sgn;
    s1.int_bits = x;
    s1.fb = '0;
    if (ex == ExpAll) begin
      s1.frac_fix = (mant != '0) ? x : sgn;
    end else if (ex < ExpBias) begin
      s1.frac_fix = x;
      s1.int_bits = sgn;
    end else if (e >= ExpW'(MantW)) begin
      s1.frac_fix = sgn;
    end else begin
      fmask = ({MantW{1'b1}} >> e[5:0]);
      s1.int_bits = x & ~{12'd0, fmask};
      s1.fb = mant & fmask;
      s1.special = (s1.fb == '0);
    end
  end
endmodule

@@ rtl/fmodf_lzc.sv @@
// Stage 2 logic: finds the position of the leading one of the fraction.
module fmodf_lzc (
  input  fmodf_pkg::s1_t s1,
  output fmodf_pkg::s2_t s2
);
  import fmodf_pkg::*;
  always_comb begin
    s2.x = s1.x;
    s2.special = s1.special;
    s2.frac_fix = s1.frac_fix;
    s2.int_bits = s1.int_bits;
    s2.fb = s1.fb;
    s2.p = '0;
    for (int i = 0; i < MantW; i++) begin
      if (s1.fb[i]) s2.p = 6'(i);
    end
  end
endmodule

@@ rtl/fmodf_norm.sv @@
// Stage 3 logic: shifts the fraction up and assembles the result pair.
module fmodf_norm (
  input  fmodf_pkg::s2_t s2,
  output logic [63:0]    frac_bits,
  output logic [63:0]    int_bits
);
  import fmodf_pkg::*;
  logic [MantW-1:0] shifted;
  logic [ExpW-1:0]  fexp;
  always_comb begin
    shifted = s2.fb << (6'(MantW) - s2.p);
    fexp = s2.x[62:52] - ExpW'(MantW) + ExpW'(s2.p);
    int_bits = s2.int_bits;
    if (s2.special) begin
      frac_bits = s2.frac_fix;
    end else begin
      frac_bits = {s2.x[63], fexp, shifted};
    end
  end
endmodule

@@ rtl/fp64_modf_split_core.sv @@
// Top level of the binary64 modf splitter: three-stage pipeline with handshakes.
// An accepted request is registered in s1_r, then in s2_r, and then in frac_r/int_r,
// from which its result is presented on the output channel.
// Throughput: one request per cycle; a stage holds only when it and every later stage are
// full and the output is not being taken, so empty stages keep moving and close up gaps.
// Reset (synchronous, active low) clears the stage valid bits; payload is not reset.
module fp64_modf_split_core (
  input logic        clk,
  input logic        rst_n,
  fmodf_if.sink      in_ch,
  fmodf_out_if.source out_ch
);
  import fmodf_pkg::*;

  // Stage registers. Valid bits travel alongside each stage's payload.
  logic        v1_r, v2_r, v3_r;
  s1_t         s1_r;
  s2_t         s2_r;
  logic [63:0] frac_r, int_r;
  s1_t         s1_nxt;
  s2_t         s2_nxt;
  logic [63:0] frac_nxt, int_nxt;
  logic        adv3, adv2, adv1;

  // Each stage moves when the stage after it is empty or moving too.
  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  fmodf_decode u_dec (.x(in_ch.data), .s1(s1_nxt));
  fmodf_lzc    u_lzc (.s1(s1_r), .s2(s2_nxt));
  fmodf_norm   u_nrm (.s2(s2_r), .frac_bits(frac_nxt), .int_bits(int_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
    if (adv1) s1_r <= s1_nxt;
    if (adv2) s2_r <= s2_nxt;
    if (adv3) begin
      frac_r <= frac_nxt;
      int_r <= int_nxt;
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.frac_bits = frac_r;
  assign out_ch.int_bits = int_r;
endmodule

@@ tb/fp64_modf_split_core_test.sv @@
// Self-checking testbench for the binary64 modf splitter: directed and random requests.
`timescale 1ns / 100ps

module fp64_modf_split_core_test;
  import fmodf_pkg::*;

  typedef struct packed {
    logic [63:0] frac_bits;
    logic [63:0] int_bits;
  } split_t;

  logic clk;
  logic rst_n;
  int   errors;
  bit   send_idle_on;   // random gaps on the request side
  bit   recv_idle_on;   // random stalls on the result side
  int   hold_off;       // cycles the receiver must still hold off
  int   hold_seq;       // bumped by the stimulus to ask for a hold-off
  int   hold_seen;      // last hold-off request already started
  split_t expected_q[$];

  fmodf_if     in_ch();
  fmodf_out_if out_ch();

  fp64_modf_split_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Works out the integral part and the exact fraction from the raw bits.
  function automatic split_t modf_split(logic [63:0] x);
    split_t      r;
    logic [63:0] sgn;
    logic [10:0] ex;
    logic [51:0] mant;
    logic [63:0] fmask;
    logic [51:0] fb;
    int          e;
    int          p;
    sgn  = x & SignBit;
    ex   = x[62:52];
    mant = x[51:0];
    if (ex == ExpAll) begin
      r.int_bits  = x;
      r.frac_bits = (mant != 0) ? x : sgn;
    end else if (ex < ExpBias) begin
      r.frac_bits = x;
      r.int_bits  = sgn;
    end else begin
      e = int'(ex) - int'(ExpBias);
      if (e >= int'(MantW)) begin
        r.frac_bits = sgn;
        r.int_bits  = x;
      end else begin
        fmask      = (64'd1 << (int'(MantW) - e)) - 64'd1;
        r.int_bits = x & ~fmask;
        fb         = mant & fmask[51:0];
        if (fb == 0) begin
          r.frac_bits = sgn;
        end else begin
          p = 0;
          for (int i = 0; i < 52; i++) begin
            if (fb[i]) begin
              p = i;
            end
          end
          r.frac_bits = sgn | (64'(int'(ex) - int'(MantW) + p) << MantW)
                      | ((64'(fb) << (int'(MantW) - p)) & 64'h000F_FFFF_FFFF_FFFF);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Offers one request and waits until it has been taken. Valid stays high
  // into the next request unless the sender decides to idle first.
  task automatic send_request(logic [63:0] x);
    while (send_idle_on && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= x;
    expected_q.push_back(modf_split(x));
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // Ready is decided at each rising edge; a hold-off forces it low for a stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_off     <= 60;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_idle_on && $urandom_range(99) < 34);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    split_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.int_bits, 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.frac_bits !== want.frac_bits) begin
          report_mismatch("frac_bits", out_ch.frac_bits, want.frac_bits);
        end
        if (out_ch.int_bits !== want.int_bits) begin
          report_mismatch("int_bits", out_ch.int_bits, want.int_bits);
        end
      end
    end
  end

  // A random value whose exponent mostly lands near the binary point, so that
  // the fraction path is exercised far more often than the special cases.
  function automatic logic [63:0] random_value();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: ;  // raw bits, any exponent
      2: x[62:52] = ($urandom_range(1)) ? ExpAll : 11'd0;
      3: x[51:0] = ($urandom_range(1)) ? 52'd0 : x[51:0] >> $urandom_range(51);
      default: x[62:52] = 11'(int'(ExpBias) - 2 + $urandom_range(56));
    endcase
    return x;
  endfunction

  task automatic test_special_cases();
    logic [63:0] vals[$];
    vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
             64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
             64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
             64'h800F_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF,
             64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0001,
             64'h3FF8_0000_0000_0000, 64'hC00C_0000_0000_0000,
             64'h4330_0000_0000_0000, 64'hC32F_FFFF_FFFF_FFFF,
             64'h432F_FFFF_FFFF_FFFE, 64'h4330_0000_0000_0001,
             64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h4059_0000_0000_0000, 64'h400921FB54442D18};
    foreach (vals[i]) begin
      send_request(vals[i]);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_value());
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so
  // the pipeline fills and must stall its input.
  task automatic test_back_pressure();
    hold_seq++;
    test_random(40);
  endtask

  initial begin
    errors       = 0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    hold_seq     = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_random(300);            // no idling at all
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_random(1450);
    test_back_pressure();
    send_idle_on = 1'b0;
    test_random(40);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
